@@ hw/rtl/ljm_pkg.sv @@
// ----------------------------------------------------------------------------
// ljm_pkg
// Shared types and constants of the latency and jitter monitor.
// ----------------------------------------------------------------------------
`default_nettype none

package ljm_pkg;

	localparam int unsigned TIME_W     = 64;
	localparam int unsigned CNT_W      = 32;
	localparam int unsigned APB_ADDR_W = 4;
	localparam int unsigned APB_DATA_W = 32;

	localparam int unsigned QUEUE_DEPTH = 4;

	localparam logic [TIME_W-1:0] MIN_START    = 64'h0000_0000_0fff_ffff;
	localparam logic [CNT_W-1:0]  SKIP_REPORTS = 32'd5;

	localparam logic [CNT_W-1:0] RST_REPORT_INTERVAL  = 32'd20000;
	localparam logic [CNT_W-1:0] RST_TRIG_THRESHOLD   = 32'd15000;
	localparam logic             RST_TRIGGER_ENABLE   = 1'b0;
	localparam logic [CNT_W-1:0] RST_SAMPLE_LIMIT     = 32'd200;

	typedef enum logic [1:0] {
		REG_REPORT_INTERVAL  = 2'd0,
		REG_TRIG_THRESHOLD   = 2'd1,
		REG_TRIGGER_ENABLE   = 2'd2,
		REG_SAMPLE_LIMIT     = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [CNT_W-1:0] report_interval;
		logic [CNT_W-1:0] trig_threshold;
		logic             trigger_enable;
		logic [CNT_W-1:0] sample_limit;
	} cfg_t;

	typedef struct packed {
		logic [TIME_W-1:0] exec_time;
		logic [TIME_W-1:0] end_time;
		logic              clear_req;
	} entry_t;

endpackage

`default_nettype wire

@@ hw/rtl/ljm_if.sv @@
// ----------------------------------------------------------------------------
// ljm_in_if / ljm_out_if
// Valid/ready channels for timestamp samples and statistics results.
// ----------------------------------------------------------------------------
`default_nettype none

interface ljm_in_if;
	logic        valid;
	logic        ready;
	logic [63:0] start_time;
	logic [63:0] end_time;
	logic        stats_reset_request;

	modport source (output valid, start_time, end_time, stats_reset_request, input ready);
	modport sink (input valid, start_time, end_time, stats_reset_request, output ready);
endinterface

interface ljm_out_if;
	logic        valid;
	logic        ready;
	logic        report_valid;
	logic        trigger_fire;
	logic        finished;
	logic [63:0] window_min;
	logic [63:0] window_max;
	logic [63:0] window_jitter;
	logic [63:0] exec_time;
	logic [63:0] all_time_min;
	logic [63:0] all_time_max;
	logic [63:0] report_gap;
	logic [31:0] sample_number;

	modport source (
		output valid, report_valid, trigger_fire, finished, window_min, window_max,
		window_jitter, exec_time, all_time_min, all_time_max, report_gap, sample_number,
		input ready
	);
	modport sink (
		input valid, report_valid, trigger_fire, finished, window_min, window_max,
		window_jitter, exec_time, all_time_min, all_time_max, report_gap, sample_number,
		output ready
	);
endinterface

`default_nettype wire

@@ hw/rtl/latency_jitter_monitor_top.sv @@
// ----------------------------------------------------------------------------
// latency_jitter_monitor_top
// Execution time and jitter monitor with windowed reports and a trigger.
// ----------------------------------------------------------------------------
// Each sample carries a start and an end timestamp; the block takes their
// absolute difference as the execution time and produces one result per
// sample. It accepts one sample per clock cycle while the queue is not full,
// and a result passes through the queue and the output registers s1 and s2.
// The rate is set by the statistics update in the back end, which folds one
// sample into the minimum, maximum, counter and trigger state each cycle.
// A short queue between the front and back end absorbs result-side stalls.
// Configuration registers are to be written over the APB port by the user
// only while no sample is in flight; the block does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module latency_jitter_monitor_top #(
	parameter int unsigned QUEUE_DEPTH = ljm_pkg::QUEUE_DEPTH
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [ljm_pkg::APB_ADDR_W-1:0] paddr,
	input  wire logic [ljm_pkg::APB_DATA_W-1:0] pwdata,
	output logic      [ljm_pkg::APB_DATA_W-1:0] prdata,
	output logic                                pready,
	ljm_in_if.sink                              sample,
	ljm_out_if.source                           stats
);

	localparam int unsigned ENTRY_W = $bits(ljm_pkg::entry_t);

	ljm_pkg::cfg_t   cfg;
	ljm_pkg::entry_t push_entry;
	ljm_pkg::entry_t pop_entry;
	logic [ENTRY_W-1:0] pop_bits;
	logic            push_valid, push_ready, pop_valid, pop_ready;

	ljm_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ljm_front u_front (
		.sample     (sample),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry)
	);

	ljm_fifo #(
		.WIDTH (ENTRY_W),
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_entry),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_bits)
	);

	assign pop_entry = ljm_pkg::entry_t'(pop_bits);

	ljm_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.q_valid (pop_valid),
		.q_ready (pop_ready),
		.q_entry (pop_entry),
		.stats   (stats)
	);

endmodule

`default_nettype wire

@@ hw/rtl/ljm_cfg.sv @@
// ----------------------------------------------------------------------------
// ljm_cfg
// APB register bank holding the monitor's configuration.
// ----------------------------------------------------------------------------
`default_nettype none

module ljm_cfg (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [ljm_pkg::APB_ADDR_W-1:0]   paddr,
	input  wire logic [ljm_pkg::APB_DATA_W-1:0]   pwdata,
	output logic      [ljm_pkg::APB_DATA_W-1:0]   prdata,
	output logic                                  pready,
	output ljm_pkg::cfg_t                         cfg
);

	ljm_pkg::cfg_t     cfg_q;
	ljm_pkg::reg_idx_t idx;
	logic              wr_en;

	assign idx    = ljm_pkg::reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.report_interval  <= ljm_pkg::RST_REPORT_INTERVAL;
			cfg_q.trig_threshold   <= ljm_pkg::RST_TRIG_THRESHOLD;
			cfg_q.trigger_enable   <= ljm_pkg::RST_TRIGGER_ENABLE;
			cfg_q.sample_limit     <= ljm_pkg::RST_SAMPLE_LIMIT;
		end else if (wr_en) begin
			unique case (idx)
				ljm_pkg::REG_REPORT_INTERVAL:  cfg_q.report_interval  <= pwdata;
				ljm_pkg::REG_TRIG_THRESHOLD:   cfg_q.trig_threshold   <= pwdata;
				ljm_pkg::REG_TRIGGER_ENABLE:   cfg_q.trigger_enable   <= pwdata[0];
				ljm_pkg::REG_SAMPLE_LIMIT:     cfg_q.sample_limit     <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			ljm_pkg::REG_REPORT_INTERVAL:  prdata = cfg_q.report_interval;
			ljm_pkg::REG_TRIG_THRESHOLD:   prdata = cfg_q.trig_threshold;
			ljm_pkg::REG_TRIGGER_ENABLE:   prdata = {31'd0, cfg_q.trigger_enable};
			ljm_pkg::REG_SAMPLE_LIMIT:     prdata = cfg_q.sample_limit;
			default:                       prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

@@ hw/rtl/ljm_front.sv @@
// ----------------------------------------------------------------------------
// ljm_front
// Accepts timestamp samples and turns each into an execution time entry.
// ----------------------------------------------------------------------------
`default_nettype none

module ljm_front (
	ljm_in_if.sink          sample,
	output logic            push_valid,
	input  wire logic       push_ready,
	output ljm_pkg::entry_t push_entry
);

	logic start_later;

	assign start_later   = sample.start_time > sample.end_time;
	assign sample.ready  = push_ready;
	assign push_valid    = sample.valid;

	always_comb begin
		push_entry.exec_time = start_later ? (sample.start_time - sample.end_time)
		                                   : (sample.end_time - sample.start_time);
		push_entry.end_time  = sample.end_time;
		push_entry.clear_req = sample.stats_reset_request;
	end

endmodule

`default_nettype wire

@@ hw/rtl/ljm_fifo.sv @@
// ----------------------------------------------------------------------------
// ljm_fifo
// Short register queue between the front and the statistics back end.
// ----------------------------------------------------------------------------
`default_nettype none

module ljm_fifo #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push_valid,
	output logic                  push_ready,
	input  wire logic [WIDTH-1:0] push_data,
	output logic                  pop_valid,
	input  wire logic             pop_ready,
	output logic      [WIDTH-1:0] pop_data
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign push_ready = count_q != CNT_W'(DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_data   = mem_q[rd_ptr_q];
	assign push       = push_valid & push_ready;
	assign pop        = pop_valid & pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count exceeds depth");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> !pop)
		else $error("pop from empty queue");

	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		((count_q == '0) || (count_q == CNT_W'(DEPTH))) |-> (wr_ptr_q == rd_ptr_q))
		else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

@@ hw/rtl/ljm_back.sv @@
// ----------------------------------------------------------------------------
// ljm_back
// Statistics state update, trigger and report formation, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ljm_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire ljm_pkg::cfg_t   cfg,
	input  wire logic            q_valid,
	output logic                 q_ready,
	input  wire ljm_pkg::entry_t q_entry,
	ljm_out_if.source            stats
);

	logic [63:0] at_min_q, at_max_q, win_min_q, win_max_q, prev_end_q;
	logic [31:0] window_count_q, report_count_q;
	logic        clear_pending_q, trigger_done_q;

	logic [63:0] ex, at_min_n, at_max_n, win_min_n, win_max_n, excess, gap;
	logic [31:0] rc_inc, rc_n;
	logic        clr_eff, ex_below, fire, close, report, do_clear, take, fin;

	logic        valid_s1, report_s1, fire_s1, fin_s1;
	logic [63:0] win_min_s1, win_max_s1, exec_s1, at_min_s1, at_max_s1, gap_s1;
	logic [31:0] num_s1;

	logic        valid_s2, report_s2, fire_s2, fin_s2;
	logic [63:0] win_min_s2, win_max_s2, jitter_s2, exec_s2, at_min_s2, at_max_s2;
	logic [63:0] gap_s2;
	logic [31:0] num_s2;

	logic        s2_ready, s1_ready;

	always_comb begin
		ex        = q_entry.exec_time;
		clr_eff   = clear_pending_q | q_entry.clear_req;
		at_min_n  = (ex < at_min_q) ? ex : at_min_q;
		at_max_n  = (ex >= at_max_q) ? ex : at_max_q;
		win_min_n = (ex < win_min_q) ? ex : win_min_q;
		win_max_n = (ex >= win_max_q) ? ex : win_max_q;
		ex_below  = ex < win_min_q;
		excess    = ex - win_min_q;
		fire      = cfg.trigger_enable & (report_count_q > ljm_pkg::SKIP_REPORTS)
		            & !trigger_done_q & !ex_below & (excess > {32'd0, cfg.trig_threshold});
		close     = window_count_q >= cfg.report_interval;
		report    = close & (report_count_q != '0);
		do_clear  = close & clr_eff;
		rc_inc    = report_count_q + 32'd1;
		rc_n      = close ? (clr_eff ? 32'd1 : rc_inc) : report_count_q;
		fin       = rc_n > cfg.sample_limit;
		gap       = q_entry.end_time - prev_end_q;
	end

	assign s2_ready = !valid_s2 | stats.ready;
	assign s1_ready = !valid_s1 | s2_ready;
	assign q_ready  = s1_ready;
	assign take     = q_valid & q_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			at_min_q        <= ljm_pkg::MIN_START;
			at_max_q        <= '0;
			win_min_q       <= ljm_pkg::MIN_START;
			win_max_q       <= '0;
			window_count_q  <= '0;
			report_count_q  <= '0;
			clear_pending_q <= 1'b0;
			trigger_done_q  <= 1'b0;
		end else if (take) begin
			at_min_q        <= do_clear ? ljm_pkg::MIN_START : at_min_n;
			at_max_q        <= do_clear ? '0 : at_max_n;
			win_min_q       <= close ? ljm_pkg::MIN_START : win_min_n;
			win_max_q       <= close ? '0 : win_max_n;
			window_count_q  <= close ? 32'd1 : window_count_q + 32'd1;
			report_count_q  <= rc_n;
			clear_pending_q <= close ? 1'b0 : clr_eff;
			trigger_done_q  <= do_clear ? 1'b0 : (trigger_done_q | fire);
		end
	end

	always_ff @(posedge clk) begin
		if (take && close) begin
			prev_end_q <= q_entry.end_time;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s1_ready) begin
				valid_s1 <= q_valid;
			end
			if (s2_ready) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			report_s1  <= report;
			fire_s1    <= fire;
			fin_s1     <= fin;
			exec_s1    <= ex;
			win_min_s1 <= report ? win_min_n : '0;
			win_max_s1 <= report ? win_max_n : '0;
			at_min_s1  <= report ? at_min_n : '0;
			at_max_s1  <= report ? at_max_n : '0;
			gap_s1     <= report ? gap : '0;
			num_s1     <= report ? report_count_q : '0;
		end
		if (valid_s1 && s2_ready) begin
			report_s2  <= report_s1;
			fire_s2    <= fire_s1;
			fin_s2     <= fin_s1;
			exec_s2    <= exec_s1;
			win_min_s2 <= win_min_s1;
			win_max_s2 <= win_max_s1;
			jitter_s2  <= win_max_s1 - win_min_s1;
			at_min_s2  <= at_min_s1;
			at_max_s2  <= at_max_s1;
			gap_s2     <= gap_s1;
			num_s2     <= num_s1;
		end
	end

	assign stats.valid         = valid_s2;
	assign stats.report_valid  = report_s2;
	assign stats.trigger_fire  = fire_s2;
	assign stats.finished      = fin_s2;
	assign stats.window_min    = win_min_s2;
	assign stats.window_max    = win_max_s2;
	assign stats.window_jitter = jitter_s2;
	assign stats.exec_time     = exec_s2;
	assign stats.all_time_min  = at_min_s2;
	assign stats.all_time_max  = at_max_s2;
	assign stats.report_gap    = gap_s2;
	assign stats.sample_number = num_s2;

	a_report_numbered: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && report_s1) |-> (num_s1 != '0))
		else $error("report issued before the first window closed");

	a_window_count_live: assert property (@(posedge clk) disable iff (!arst_n)
		$past(take) |-> (window_count_q != '0))
		else $error("window count returned to zero");

	a_window_within_all_time: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && report_s1) |->
			((at_min_s1 <= win_min_s1) && (win_min_s1 <= win_max_s1)
			 && (win_max_s1 <= at_max_s1)))
		else $error("window extremes lie outside all-time extremes");

endmodule

`default_nettype wire
